// ===== design/pcol_pkg.sv =====
// Shared types and constants for the primitive pair collision block.
package pcol_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  // Q12.4: one pixel is 16, half a pixel is 8
  localparam int ONE_PIXEL  = 16;
  localparam int HALF_PIXEL = 8;

  // register stages inside one lane
  localparam int LANE_STAGES = 5;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_CIRCLE  = 2'd1,
    KIND_SEGMENT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_NEAR   = 2'd1,
    MODE_SEG    = 2'd2,
    MODE_SEGSEG = 2'd3
  } mode_t;

  // per-lane flags handed to the final combine
  typedef struct packed {
    logic hit;
    logic near_a;
    logic same;
    logic cr_neg;
    logic cr_zero;
  } lane_res_t;

endpackage

// ===== design/pcol_ifs.sv =====
// Item channel interfaces for the primitive pair collision block.
interface pcol_in_if #(
  parameter int COORD_WIDTH = pcol_pkg::COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [1:0]                    first_kind;
  logic signed [COORD_WIDTH-1:0] first_ax;
  logic signed [COORD_WIDTH-1:0] first_ay;
  logic signed [COORD_WIDTH-1:0] first_bx;
  logic signed [COORD_WIDTH-1:0] first_by;
  logic [COORD_WIDTH-2:0]        first_radius;
  logic [1:0]                    second_kind;
  logic signed [COORD_WIDTH-1:0] second_ax;
  logic signed [COORD_WIDTH-1:0] second_ay;
  logic signed [COORD_WIDTH-1:0] second_bx;
  logic signed [COORD_WIDTH-1:0] second_by;
  logic [COORD_WIDTH-2:0]        second_radius;

  modport source (
    output valid, first_kind, first_ax, first_ay, first_bx, first_by, first_radius,
           second_kind, second_ax, second_ay, second_bx, second_by, second_radius,
    input  ready
  );
  modport sink (
    input  valid, first_kind, first_ax, first_ay, first_bx, first_by, first_radius,
           second_kind, second_ax, second_ay, second_bx, second_by, second_radius,
    output ready
  );
endinterface

interface pcol_out_if ();
  logic valid;
  logic ready;
  logic collided;

  modport source (output valid, collided, input ready);
  modport sink (input valid, collided, output ready);
endinterface

// ===== design/pcol_mul.sv =====
// Two-stage unsigned multiplier built from four half-width partial products.
module pcol_mul #(
  parameter int AW = 33,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        a,
  input  logic [BW-1:0]        b,
  output logic [AW+BW-1:0]     p
);
  localparam int HA = (AW + 1) / 2;
  localparam int HB = (BW + 1) / 2;
  localparam int PW = AW + BW;

  logic [HA+HB-1:0]           pp_ll_r;
  logic [HA+BW-HB-1:0]        pp_lh_r;
  logic [AW-HA+HB-1:0]        pp_hl_r;
  logic [AW-HA+BW-HB-1:0]     pp_hh_r;
  logic [PW-1:0]              p_r;
  logic [PW-1:0]              p_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= a[HA-1:0]  * b[HB-1:0];
      pp_lh_r <= a[HA-1:0]  * b[BW-1:HB];
      pp_hl_r <= a[AW-1:HA] * b[HB-1:0];
      pp_hh_r <= a[AW-1:HA] * b[BW-1:HB];
      p_r     <= p_nxt;
    end
  end

  always_comb begin
    p_nxt = PW'(pp_ll_r) + (PW'(pp_lh_r) << HB) + (PW'(pp_hl_r) << HA)
          + (PW'(pp_hh_r) << (HA + HB));
  end

  assign p = p_r;
endmodule

// ===== design/pcol_lane.sv =====
// One circle-against-segment lane: differences, products, sums, wide squares.
module pcol_lane #(
  parameter int COORD_WIDTH = pcol_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] cx,
  input  logic signed [COORD_WIDTH-1:0] cy,
  input  logic signed [COORD_WIDTH-1:0] ax,
  input  logic signed [COORD_WIDTH-1:0] ay,
  input  logic signed [COORD_WIDTH-1:0] bx,
  input  logic signed [COORD_WIDTH-1:0] by,
  input  logic [COORD_WIDTH-1:0]        n,
  output pcol_pkg::lane_res_t           res
);
  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W + 2;   // signed product
  localparam int SW = 2 * W + 1;   // unsigned sum of squares

  logic signed [W:0] cxe, cye, axe, aye, bxe, bye;
  assign cxe = {cx[W-1], cx};
  assign cye = {cy[W-1], cy};
  assign axe = {ax[W-1], ax};
  assign aye = {ay[W-1], ay};
  assign bxe = {bx[W-1], bx};
  assign bye = {by[W-1], by};

  // stage A: differences
  logic signed [W:0] dxa_r, dya_r, dxb_r, dyb_r, sdx_r, sdy_r;
  logic signed [W:0] acx_r, acy_r, bcx_r, bcy_r;
  logic [W-1:0]      nn_r, n_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dxa_r <= cxe - axe;
      dya_r <= cye - aye;
      dxb_r <= cxe - bxe;
      dyb_r <= cye - bye;
      sdx_r <= bxe - axe;
      sdy_r <= bye - aye;
      acx_r <= axe - cxe;
      acy_r <= aye - cye;
      bcx_r <= bxe - cxe;
      bcy_r <= bye - cye;
      nn_r  <= (n == '0) ? W'(pcol_pkg::ONE_PIXEL) : n;
      n_r   <= n;
    end
  end

  // stage B: products
  logic signed [PW-1:0] sq_dxa_r, sq_dya_r, sq_dxb_r, sq_dyb_r, sq_sdx_r, sq_sdy_r;
  logic signed [PW-1:0] crp1_r, crp2_r, dpa1_r, dpa2_r, dpb1_r, dpb2_r;
  logic [2*W-1:0]       nn2_r, n2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_dxa_r <= dxa_r * dxa_r;
      sq_dya_r <= dya_r * dya_r;
      sq_dxb_r <= dxb_r * dxb_r;
      sq_dyb_r <= dyb_r * dyb_r;
      sq_sdx_r <= sdx_r * sdx_r;
      sq_sdy_r <= sdy_r * sdy_r;
      crp1_r   <= acx_r * sdy_r;
      crp2_r   <= acy_r * sdx_r;
      dpa1_r   <= sdx_r * acx_r;
      dpa2_r   <= sdy_r * acy_r;
      dpb1_r   <= sdx_r * bcx_r;
      dpb2_r   <= sdy_r * bcy_r;
      nn2_r    <= nn_r * nn_r;
      n2_r     <= n_r * n_r;
    end
  end

  // stage C: sums and the short compares
  logic [SW-1:0]        da2, db2, len2;
  logic signed [PW-1:0] cr, crn, sa, sb;
  logic [SW-1:0]        len2_r, crmag_r;
  logic [2*W-1:0]       n2c_r;
  logic                 near_a_c_r, near_b_c_r, same_c_r, cr_neg_c_r, cr_zero_c_r;
  logic                 sa_neg_c_r, sa_pos_c_r, sb_neg_c_r, sb_pos_c_r;

  always_comb begin
    da2  = {1'b0, sq_dxa_r[2*W-1:0]} + {1'b0, sq_dya_r[2*W-1:0]};
    db2  = {1'b0, sq_dxb_r[2*W-1:0]} + {1'b0, sq_dyb_r[2*W-1:0]};
    len2 = {1'b0, sq_sdx_r[2*W-1:0]} + {1'b0, sq_sdy_r[2*W-1:0]};
    cr   = crp1_r - crp2_r;
    crn  = -cr;
    sa   = dpa1_r + dpa2_r;
    sb   = dpb1_r + dpb2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_a_c_r  <= {1'b0, nn2_r} >= da2;
      near_b_c_r  <= {1'b0, nn2_r} >= db2;
      same_c_r    <= len2 <= SW'(pcol_pkg::ONE_PIXEL * pcol_pkg::ONE_PIXEL);
      len2_r      <= len2;
      n2c_r       <= n2_r;
      cr_neg_c_r  <= cr[PW-1];
      cr_zero_c_r <= (cr == '0);
      crmag_r     <= cr[PW-1] ? crn[SW-1:0] : cr[SW-1:0];
      sa_neg_c_r  <= sa[PW-1];
      sa_pos_c_r  <= !sa[PW-1] && (sa != '0);
      sb_neg_c_r  <= sb[PW-1];
      sb_pos_c_r  <= !sb[PW-1] && (sb != '0);
    end
  end

  // stages D and E: wide squares for the line distance
  logic [SW+2*W-1:0] lhs;
  logic [2*SW-1:0]   rhs;

  pcol_mul #(.AW(SW), .BW(2 * W)) u_mul_len (
    .clk (clk), .en (en), .a (len2_r), .b (n2c_r), .p (lhs)
  );

  pcol_mul #(.AW(SW), .BW(SW)) u_mul_cr (
    .clk (clk), .en (en), .a (crmag_r), .b (crmag_r), .p (rhs)
  );

  // flags ride alongside the multipliers
  logic [1:0] near_a_q, near_b_q, same_q, cr_neg_q, cr_zero_q;
  logic [1:0] sa_neg_q, sa_pos_q, sb_neg_q, sb_pos_q;

  always_ff @(posedge clk) begin
    if (en) begin
      near_a_q  <= {near_a_q[0], near_a_c_r};
      near_b_q  <= {near_b_q[0], near_b_c_r};
      same_q    <= {same_q[0], same_c_r};
      cr_neg_q  <= {cr_neg_q[0], cr_neg_c_r};
      cr_zero_q <= {cr_zero_q[0], cr_zero_c_r};
      sa_neg_q  <= {sa_neg_q[0], sa_neg_c_r};
      sa_pos_q  <= {sa_pos_q[0], sa_pos_c_r};
      sb_neg_q  <= {sb_neg_q[0], sb_neg_c_r};
      sb_pos_q  <= {sb_pos_q[0], sb_pos_c_r};
    end
  end

  logic near_line, proj_in;

  always_comb begin
    // degenerate segment: distance to its start only
    near_line = same_q[1] ? near_a_q[1] : ({1'b0, lhs} >= rhs);
    proj_in   = (sa_neg_q[1] && sb_pos_q[1]) || (sa_pos_q[1] && sb_neg_q[1]);
    res.hit     = near_a_q[1] || near_b_q[1] || (near_line && !same_q[1] && proj_in);
    res.near_a  = near_a_q[1];
    res.same    = same_q[1];
    res.cr_neg  = cr_neg_q[1];
    res.cr_zero = cr_zero_q[1];
  end
endmodule

// ===== design/primitive_pair_collision.sv =====
// Path: an accepted item passes the input stage, the lane stages and then the output register.
// Throughput: one item per cycle unless stalled; four lanes of 14 multipliers and two split
//   wide multipliers each are fully pipelined, so only a stall limits the rate.
// Stall: the whole pipe holds while the output register is full and not taken.
// Reset: synchronous, active low; clears all stage valid bits, no memories.
module primitive_pair_collision #(
  parameter int COORD_WIDTH = pcol_pkg::COORD_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pcol_in_if.sink    in_if,
  pcol_out_if.source out_if
);
  localparam int W     = COORD_WIDTH;
  localparam int DEPTH = pcol_pkg::LANE_STAGES + 1;   // input stage plus lane stages

  // advance every stage together when the output slot frees up
  logic adv;
  assign adv         = !out_if.valid || out_if.ready;
  assign in_if.ready = adv;

  // input stage: hold the accepted item
  logic [1:0]          k1_r, k2_r;
  logic signed [W-1:0] f_ax_r, f_ay_r, f_bx_r, f_by_r;
  logic signed [W-1:0] s_ax_r, s_ay_r, s_bx_r, s_by_r;
  logic [W-2:0]        f_r_r, s_r_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r   <= in_if.first_kind;
      f_ax_r <= in_if.first_ax;
      f_ay_r <= in_if.first_ay;
      f_bx_r <= in_if.first_bx;
      f_by_r <= in_if.first_by;
      f_r_r  <= in_if.first_radius;
      k2_r   <= in_if.second_kind;
      s_ax_r <= in_if.second_ax;
      s_ay_r <= in_if.second_ay;
      s_bx_r <= in_if.second_bx;
      s_by_r <= in_if.second_by;
      s_r_r  <= in_if.second_radius;
    end
  end

  // order the pair so the lower kind comes first
  logic                swap;
  logic [1:0]          kp, kq;
  logic signed [W-1:0] p_ax, p_ay, p_bx, p_by, q_ax, q_ay, q_bx, q_by;
  logic [W-2:0]        p_r, q_r;
  logic [W-1:0]        n0;
  pcol_pkg::mode_t     mode;

  always_comb begin
    swap = k1_r > k2_r;
    kp   = swap ? k2_r : k1_r;
    kq   = swap ? k1_r : k2_r;
    p_ax = swap ? s_ax_r : f_ax_r;
    p_ay = swap ? s_ay_r : f_ay_r;
    p_bx = swap ? s_bx_r : f_bx_r;
    p_by = swap ? s_by_r : f_by_r;
    p_r  = swap ? s_r_r  : f_r_r;
    q_ax = swap ? f_ax_r : s_ax_r;
    q_ay = swap ? f_ay_r : s_ay_r;
    q_bx = swap ? f_bx_r : s_bx_r;
    q_by = swap ? f_by_r : s_by_r;
    q_r  = swap ? f_r_r  : s_r_r;
  end

  // pick the case and the test radius of lane 0
  always_comb begin
    mode = pcol_pkg::MODE_NEAR;
    n0   = W'(pcol_pkg::HALF_PIXEL);
    if (kq > pcol_pkg::KIND_SEGMENT) begin
      mode = pcol_pkg::MODE_NONE;
    end else if (kp == pcol_pkg::KIND_SEGMENT) begin
      mode = pcol_pkg::MODE_SEGSEG;
    end else if (kq == pcol_pkg::KIND_SEGMENT) begin
      mode = pcol_pkg::MODE_SEG;
      n0   = (kp == pcol_pkg::KIND_CIRCLE) ? W'(p_r) : W'(pcol_pkg::HALF_PIXEL);
    end else if (kq == pcol_pkg::KIND_CIRCLE) begin
      n0   = (kp == pcol_pkg::KIND_CIRCLE) ? W'(p_r) + W'(q_r) : W'(q_r);
    end else begin
      n0   = W'(pcol_pkg::ONE_PIXEL);
    end
  end

  // four lanes: both ends of each segment against the other segment;
  // lane 0 also serves every case that has no segment pair
  pcol_pkg::lane_res_t res0, res1, res2, res3;

  pcol_lane #(.COORD_WIDTH(W)) u_lane0 (
    .clk (clk), .en (adv), .cx (p_ax), .cy (p_ay),
    .ax (q_ax), .ay (q_ay), .bx (q_bx), .by (q_by), .n (n0), .res (res0)
  );
  pcol_lane #(.COORD_WIDTH(W)) u_lane1 (
    .clk (clk), .en (adv), .cx (p_bx), .cy (p_by),
    .ax (q_ax), .ay (q_ay), .bx (q_bx), .by (q_by),
    .n (W'(pcol_pkg::HALF_PIXEL)), .res (res1)
  );
  pcol_lane #(.COORD_WIDTH(W)) u_lane2 (
    .clk (clk), .en (adv), .cx (q_ax), .cy (q_ay),
    .ax (p_ax), .ay (p_ay), .bx (p_bx), .by (p_by),
    .n (W'(pcol_pkg::HALF_PIXEL)), .res (res2)
  );
  pcol_lane #(.COORD_WIDTH(W)) u_lane3 (
    .clk (clk), .en (adv), .cx (q_bx), .cy (q_by),
    .ax (p_ax), .ay (p_ay), .bx (p_bx), .by (p_by),
    .n (W'(pcol_pkg::HALF_PIXEL)), .res (res3)
  );

  // valid bits and case codes travel with the lanes; the input stage works
  // its case out from its own fields
  logic [DEPTH-1:0]     vld_r;
  pcol_pkg::mode_t      mode_r [1:DEPTH-1];
  logic                 out_valid_r;
  logic                 collided_r;
  logic                 collided_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_if.valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r[1] <= mode;
      for (int i = 2; i < DEPTH; i++) begin
        mode_r[i] <= mode_r[i-1];
      end
      collided_r <= collided_nxt;
    end
  end

  // segment-segment: with no lane hit, fails when either segment's ends lie on one side
  logic same_side_q, same_side_p;

  always_comb begin
    same_side_q = res0.same
               || (!res0.cr_neg && !res1.cr_neg)
               || ((res0.cr_neg || res0.cr_zero) && (res1.cr_neg || res1.cr_zero));
    same_side_p = res2.same
               || (!res2.cr_neg && !res3.cr_neg)
               || ((res2.cr_neg || res2.cr_zero) && (res3.cr_neg || res3.cr_zero));
    case (mode_r[DEPTH-1])
      pcol_pkg::MODE_NONE:   collided_nxt = 1'b0;
      pcol_pkg::MODE_NEAR:   collided_nxt = res0.near_a;
      pcol_pkg::MODE_SEG:    collided_nxt = res0.hit;
      pcol_pkg::MODE_SEGSEG: collided_nxt = res0.hit || res1.hit || res2.hit || res3.hit
                                         || (!same_side_q && !same_side_p);
      default:               collided_nxt = 1'b0;
    endcase
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.collided = collided_r;

  // a stall freezes every stage
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r) && $stable(out_valid_r))
    else $error("pipeline moved during a stall");

  // the last lane stage always lands in the output register
  a_last_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[DEPTH-1] |=> out_valid_r)
    else $error("item lost at the output register");

  // no valid bit survives reset
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0) && !out_valid_r)
    else $error("valid bits not cleared by reset");
endmodule
